// ----- sv/pwd_pkg.sv -----
package pwd_pkg;

  localparam int DEF_WINDOW        = 8;
  localparam int DEF_DISTANCE_BITS = 16;

  localparam int REG_BITS       = 16;
  localparam int CFG_INDEX_BITS = 3;

  localparam logic [REG_BITS-1:0] RST_JUMP   = 16'd200;
  localparam logic [REG_BITS-1:0] RST_STABLE = 16'd50;
  localparam logic [REG_BITS-1:0] RST_MAX    = 16'd4000;
  localparam logic [REG_BITS-1:0] RST_MIN    = 16'd100;
  localparam logic [REG_BITS-1:0] RST_FILL   = 16'd0;

  typedef enum logic [1:0] {
    WEAR_NONE = 2'd0,
    WEAR_ON   = 2'd1,
    WEAR_OFF  = 2'd2
  } wear_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_JUMP   = 3'd0,
    CFG_STABLE = 3'd1,
    CFG_MAX    = 3'd2,
    CFG_MIN    = 3'd3,
    CFG_FILL   = 3'd4
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_DIFF,
    ST_DECIDE,
    ST_PUSH2,
    ST_OUT
  } pwd_state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic reload;
  } pwd_win_ctl_t;

endpackage

// ----- sv/proximity_wear_detector.sv -----
// Flow: an accepted sample reads the n filled window entries (n up to WINDOW), one read a
// cycle, into a sum of SW = DISTANCE_BITS + clog2(WINDOW+1) bits; the bit-serial divider then
// forms the average, skipped with an empty window. The block takes no new sample until it is
// through with the last one; a result not yet taken holds the next sample in its output step
// until out_tready.
// Reset: rst_n sync, active low; defaults loaded, entries read fill_level, pointer WINDOW, none.
module proximity_wear_detector
  import pwd_pkg::*;
#(
  parameter int WINDOW        = DEF_WINDOW,
  parameter int DISTANCE_BITS = DEF_DISTANCE_BITS,
  localparam int TW = ((DISTANCE_BITS + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input stream
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [TW-1:0]             in_tdata,   // [DISTANCE_BITS-1:0] distance
  // result stream
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [7:0]                out_tdata,  // [1:0] wear_state
  // register writes
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [REG_BITS-1:0]       cfg_data
);

  localparam int DB = DISTANCE_BITS;
  localparam int PW = $clog2(WINDOW + 1);             // write pointer, holds 0..WINDOW
  localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SW = DB + PW;                        // window sum
  localparam int MW = (DB > REG_BITS) ? DB : REG_BITS; // compare width

  pwd_state_t state_r, state_nxt;

  // configuration registers
  logic [REG_BITS-1:0] jt_r, jt_nxt;
  logic [REG_BITS-1:0] st_r, st_nxt;
  logic [REG_BITS-1:0] max_r, max_nxt;
  logic [REG_BITS-1:0] min_r, min_nxt;
  logic [REG_BITS-1:0] fill_r, fill_nxt;

  // window bookkeeping and wear state
  logic [PW-1:0] ptr_r, ptr_nxt;
  logic          full_r, full_nxt;
  wear_t         wear_r, wear_nxt;

  // per-sample working registers
  logic [DB-1:0] d_r, d_nxt;
  logic [SW-1:0] acc_r, acc_nxt;
  logic [PW-1:0] n_r, n_nxt;
  logic [PW-1:0] iss_r, iss_nxt;
  logic          rvld_r, rvld_nxt;
  logic [DB-1:0] avg_r, avg_nxt;
  logic          neg_r, neg_nxt;
  logic [DB-1:0] absd_r, absd_nxt;
  wear_t         rep_r, rep_nxt;
  logic          push2_r, push2_nxt;

  // result register
  logic          out_vld_r, out_vld_nxt;
  wear_t         out_wear_r, out_wear_nxt;

  // window memory and divider hookup
  pwd_win_ctl_t  win_ctl;
  logic [IW-1:0] wr_addr;
  logic [DB-1:0] rd_data;
  logic          div_start;
  logic          div_done;
  logic [SW-1:0] div_q;

  // push unit, shared by the first and second push of a sample
  logic          push_en;
  logic          push_clr;
  logic [PW-1:0] bptr;
  logic          bfull;
  logic          wrap;
  logic [PW-1:0] waddr_pw;

  // decision compares
  logic [MW-1:0] fill_mw;
  logic [MW-1:0] d_mw;
  logic [MW-1:0] absd_mw;
  logic          jump;
  logic          stab;
  logic          drop;
  logic          hi;
  logic          lo;

  logic in_acc;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  assign fill_mw = MW'(fill_r);
  assign d_mw    = MW'(d_r);
  assign absd_mw = MW'(absd_r);

  assign jump = absd_mw > MW'(jt_r);
  assign stab = absd_mw <= MW'(st_r);
  assign drop = (wear_r == WEAR_OFF) && neg_r && !stab;
  assign hi   = d_mw > MW'(max_r);
  assign lo   = d_mw < MW'(min_r);

  always_comb begin
    state_nxt    = state_r;
    jt_nxt       = jt_r;
    st_nxt       = st_r;
    max_nxt      = max_r;
    min_nxt      = min_r;
    fill_nxt     = fill_r;
    ptr_nxt      = ptr_r;
    full_nxt     = full_r;
    wear_nxt     = wear_r;
    d_nxt        = d_r;
    acc_nxt      = acc_r;
    n_nxt        = n_r;
    iss_nxt      = iss_r;
    avg_nxt      = avg_r;
    neg_nxt      = neg_r;
    absd_nxt     = absd_r;
    rep_nxt      = rep_r;
    push2_nxt    = push2_r;
    out_wear_nxt = out_wear_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    win_ctl      = '0;
    div_start    = 1'b0;
    push_en      = 1'b0;
    push_clr     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          d_nxt     = in_tdata[DB-1:0];
          acc_nxt   = '0;
          iss_nxt   = '0;
          n_nxt     = full_r ? PW'(WINDOW) : ptr_r;
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        // issue one read a cycle, accumulate as data returns
        if (iss_r != n_r) begin
          win_ctl.rd_en = 1'b1;
          iss_nxt       = iss_r + 1'b1;
        end
        if (rvld_r) begin
          acc_nxt = acc_r + SW'(rd_data);
        end
        if ((iss_r == n_r) && !rvld_r) begin
          if (n_r == '0) begin
            avg_nxt   = '0;
            state_nxt = ST_DIFF;
          end else begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          avg_nxt   = div_q[DB-1:0];
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: begin
        neg_nxt   = d_r < avg_r;
        absd_nxt  = (d_r < avg_r) ? (avg_r - d_r) : (d_r - avg_r);
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (jump) begin
          // large jump: flip at once, restart the window with this sample
          wear_nxt  = neg_r ? WEAR_OFF : WEAR_ON;
          rep_nxt   = neg_r ? WEAR_OFF : WEAR_ON;
          push_en   = 1'b1;
          push_clr  = 1'b1;
          push2_nxt = 1'b0;
        end else begin
          push_en  = stab || drop;
          push_clr = drop;
          if (hi) begin
            wear_nxt  = WEAR_ON;
            rep_nxt   = WEAR_ON;
            push2_nxt = 1'b1;
          end else if (lo) begin
            wear_nxt  = WEAR_OFF;
            rep_nxt   = WEAR_OFF;
            push2_nxt = 1'b1;
          end else begin
            rep_nxt   = WEAR_NONE;
            push2_nxt = 1'b0;
          end
        end
        state_nxt = ST_PUSH2;
      end
      ST_PUSH2: begin
        push_en   = push2_r;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // hold until the result register is free
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_wear_nxt = rep_r;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // push: wrap the pointer first, then store and advance
    bptr     = push_clr ? '0 : ptr_r;
    bfull    = push_clr ? 1'b0 : full_r;
    wrap     = (bptr == PW'(WINDOW));
    waddr_pw = wrap ? '0 : bptr;
    wr_addr  = waddr_pw[IW-1:0];
    if (push_en) begin
      win_ctl.wr_en = 1'b1;
      ptr_nxt       = waddr_pw + 1'b1;
      full_nxt      = wrap || bfull;
    end

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_JUMP:   jt_nxt  = cfg_data;
        CFG_STABLE: st_nxt  = cfg_data;
        CFG_MAX:    max_nxt = cfg_data;
        CFG_MIN:    min_nxt = cfg_data;
        CFG_FILL: begin
          // reload: every entry reads as the new fill level
          fill_nxt       = cfg_data;
          win_ctl.reload = 1'b1;
          ptr_nxt        = PW'(WINDOW);
          full_nxt       = 1'b0;
        end
        default: ;
      endcase
    end

    rvld_nxt = win_ctl.rd_en;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      jt_r      <= RST_JUMP;
      st_r      <= RST_STABLE;
      max_r     <= RST_MAX;
      min_r     <= RST_MIN;
      fill_r    <= RST_FILL;
      ptr_r     <= PW'(WINDOW);
      full_r    <= 1'b0;
      wear_r    <= WEAR_NONE;
      rvld_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      jt_r      <= jt_nxt;
      st_r      <= st_nxt;
      max_r     <= max_nxt;
      min_r     <= min_nxt;
      fill_r    <= fill_nxt;
      ptr_r     <= ptr_nxt;
      full_r    <= full_nxt;
      wear_r    <= wear_nxt;
      rvld_r    <= rvld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r        <= d_nxt;
    acc_r      <= acc_nxt;
    n_r        <= n_nxt;
    iss_r      <= iss_nxt;
    avg_r      <= avg_nxt;
    neg_r      <= neg_nxt;
    absd_r     <= absd_nxt;
    rep_r      <= rep_nxt;
    push2_r    <= push2_nxt;
    out_wear_r <= out_wear_nxt;
  end

  pwd_window #(
    .WINDOW        (WINDOW),
    .DISTANCE_BITS (DB)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (win_ctl),
    .rd_addr (iss_r[IW-1:0]),
    .wr_addr (wr_addr),
    .wr_data (d_r),
    .fill    (fill_mw[DB-1:0]),
    .rd_data (rd_data)
  );

  pwd_div #(
    .DW (SW),
    .VW (PW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_r),
    .divisor  (n_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'b0, out_wear_r};

`ifndef NO_ASSERTIONS
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= PW'(WINDOW))
    else $error("write pointer beyond window");

  a_full_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |-> (ptr_r != '0))
    else $error("full window with empty pointer");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second transaction accepted while busy");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside divide state");
`endif

endmodule

// ----- sv/pwd_window.sv -----
module pwd_window
  import pwd_pkg::*;
#(
  parameter int WINDOW        = DEF_WINDOW,
  parameter int DISTANCE_BITS = DEF_DISTANCE_BITS,
  localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  pwd_win_ctl_t             ctl,
  input  logic [IW-1:0]            rd_addr,
  input  logic [IW-1:0]            wr_addr,
  input  logic [DISTANCE_BITS-1:0] wr_data,
  input  logic [DISTANCE_BITS-1:0] fill,
  output logic [DISTANCE_BITS-1:0] rd_data
);

  logic [DISTANCE_BITS-1:0] mem [WINDOW];
  logic [WINDOW-1:0]        valid_r;
  logic [DISTANCE_BITS-1:0] mem_q_r;
  logic                     vbit_r;

  // entries not written since the last reload read as the fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ctl.reload) begin
      valid_r <= '0;
    end else if (ctl.wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      mem_q_r <= mem[rd_addr];
      vbit_r  <= valid_r[rd_addr];
    end
  end

  assign rd_data = vbit_r ? mem_q_r : fill;

endmodule

// ----- sv/pwd_div.sv -----
module pwd_div #(
  parameter int DW = 20,
  parameter int VW = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] dq_r, dq_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [VW-1:0] dvs_r, dvs_nxt;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          fits;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial    = {rem_r, dq_r[DW-1]};
    fits     = (trial >= {1'b0, dvs_r});
    diff     = trial - {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DW);
      dq_nxt   = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[VW-1:0] : trial[VW-1:0];
      dq_nxt  = {dq_r[DW-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = dq_r;

endmodule

// ----- tb/proximity_wear_detector_test.sv -----
`timescale 1ns / 1ps

module proximity_wear_detector_test;
  import pwd_pkg::*;

  localparam int WIN         = DEF_WINDOW;
  localparam int DIST_W      = DEF_DISTANCE_BITS;
  localparam int TDATA_W     = ((DIST_W + 7) / 8) * 8;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 240;
  localparam int IDLE_PCT    = 13;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 50;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_MAX  = 10;

  // Wear-state predictor plus the queue of wear reports still owed by the block.
  class wear_scoreboard;
    logic [REG_BITS-1:0] jump_thr;
    logic [REG_BITS-1:0] stable_thr;
    logic [REG_BITS-1:0] max_dist;
    logic [REG_BITS-1:0] min_dist;
    logic [REG_BITS-1:0] fill_val;
    logic [DIST_W-1:0]   entries [WIN];
    int unsigned         wr_ptr;
    bit                  full;
    wear_t               wear;
    wear_t               owed_q [$];
    int unsigned         mismatches;

    function new();
      jump_thr   = RST_JUMP;
      stable_thr = RST_STABLE;
      max_dist   = RST_MAX;
      min_dist   = RST_MIN;
      fill_val   = RST_FILL;
      wear       = WEAR_NONE;
      mismatches = 0;
      reload_window();
    endfunction

    function void reload_window();
      foreach (entries[i]) entries[i] = fill_val[DIST_W-1:0];
      wr_ptr = WIN;
      full   = 1'b0;
    endfunction

    function void clear_window();
      foreach (entries[i]) entries[i] = '0;
      wr_ptr = 0;
      full   = 1'b0;
    endfunction

    function void push(logic [DIST_W-1:0] d);
      if (wr_ptr >= WIN) begin
        full   = 1'b1;
        wr_ptr = 0;
      end
      entries[wr_ptr] = d;
      wr_ptr++;
    endfunction

    function longint baseline();
      longint      sum;
      int unsigned n;
      sum = 0;
      n   = full ? WIN : wr_ptr;
      if (n == 0) return 0;
      for (int i = 0; i < n; i++) sum += longint'(entries[i]);
      return sum / longint'(n);
    endfunction

    function void note_config(logic [CFG_INDEX_BITS-1:0] idx, logic [REG_BITS-1:0] val);
      case (idx)
        CFG_JUMP:   jump_thr   = val;
        CFG_STABLE: stable_thr = val;
        CFG_MAX:    max_dist   = val;
        CFG_MIN:    min_dist   = val;
        CFG_FILL: begin
          fill_val = val;
          reload_window();
        end
        default: ;  // unmapped index: the block drops the write
      endcase
    endfunction

    function void note_sample(logic [DIST_W-1:0] d);
      longint diff;
      longint jt;
      longint st;
      wear_t  rpt;
      diff = longint'(d) - baseline();
      jt   = longint'(jump_thr);
      st   = longint'(stable_thr);
      rpt  = WEAR_NONE;
      if (diff > jt) begin
        wear = WEAR_ON;
        clear_window();
        push(d);
        rpt = WEAR_ON;
      end else if (diff < -jt) begin
        wear = WEAR_OFF;
        clear_window();
        push(d);
        rpt = WEAR_OFF;
      end else begin
        if (diff <= st && diff >= -st) begin
          push(d);
        end else if (wear == WEAR_OFF && diff < -st) begin
          clear_window();
          push(d);
        end
        // range stage pushes the sample a second time
        if (d > max_dist) begin
          wear = WEAR_ON;
          push(d);
          rpt = WEAR_ON;
        end else if (d < min_dist) begin
          wear = WEAR_OFF;
          push(d);
          rpt = WEAR_OFF;
        end
      end
      owed_q.push_back(rpt);
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= REPORT_MAX) $display("[%0t] %s", $time, msg);
    endfunction

    function void check(logic [7:0] tdata);
      wear_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("unexpected wear report %b", tdata[1:0]));
        return;
      end
      want = owed_q.pop_front();
      if (tdata[1:0] !== want)
        report($sformatf("wear_state mismatch: expected %0d (%s), got %b",
                         want, want.name(), tdata[1:0]));
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n      = 1'b0;
  logic                      in_tvalid  = 1'b0;
  logic                      in_tready;
  logic [TDATA_W-1:0]        in_tdata   = '0;  // [DIST_W-1:0] distance
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [7:0]                out_tdata;        // [1:0] wear_state
  logic                      cfg_valid  = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index  = '0;
  logic [REG_BITS-1:0]       cfg_data   = '0;

  wear_scoreboard sb;
  bit             steady       = 1'b0;  // no idling on either side while set
  int             hold_request = 0;     // receiver hold-off, picked up by the sink process
  int             hold_left    = 0;
  int unsigned    cycle_count  = 0;

  proximity_wear_detector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sink side: stall at random, or hold off for a long stretch when asked so the
  // block backs up and drops in_tready while the source keeps offering samples.
  always @(negedge clk) begin
    if (hold_left == 0 && hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Check every wear report transaction against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check(out_tdata);
  end

  // Watchdog: abort a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Driving tasks enter and leave at a falling edge. They leave valid high after
  // the transaction; the caller drops it once the run of transactions is over.
  task automatic send_sample(input logic [DIST_W-1:0] d);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= TDATA_W'(d);
    do @(posedge clk); while (!in_tready);
    sb.note_sample(d);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [REG_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.note_config(idx, val);
    @(negedge clk);
  endtask

  task automatic configure(input logic [REG_BITS-1:0] jt, input logic [REG_BITS-1:0] st,
                           input logic [REG_BITS-1:0] mx, input logic [REG_BITS-1:0] mn,
                           input logic [REG_BITS-1:0] fl, input bit unmapped);
    write_reg(CFG_JUMP, jt);
    write_reg(CFG_STABLE, st);
    write_reg(CFG_MAX, mx);
    write_reg(CFG_MIN, mn);
    write_reg(CFG_FILL, fl);
    // unmapped indexes must leave every register alone
    if (unmapped)
      for (int idx = int'(CFG_FILL) + 1; idx < (1 << CFG_INDEX_BITS); idx++)
        write_reg(CFG_INDEX_BITS'(idx), REG_BITS'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Hold until every predicted report has come back; realign to a falling edge.
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [DIST_W-1:0] clamp_distance(longint v);
    if (v < 0) return '0;
    if (v > longint'({DIST_W{1'b1}})) return '1;
    return v[DIST_W-1:0];
  endfunction

  // Aim samples at the current baseline and thresholds so the window fills, wraps
  // and restarts often; the rest hits the range limits, the extremes, or anything.
  function automatic logic [DIST_W-1:0] pick_distance();
    longint      base;
    longint      jt;
    longint      st;
    longint      off;
    longint      anchor;
    int unsigned kind;
    base = sb.baseline();
    jt   = longint'(sb.jump_thr);
    st   = longint'(sb.stable_thr);
    kind = $urandom_range(99);
    if (kind < 40) begin
      off = longint'($urandom_range(int'(2 * st))) - st;
    end else if (kind < 55) begin
      off = (jt > st) ? longint'($urandom_range(int'(jt), int'(st + 1))) : st + 1;
      if ($urandom_range(1)) off = -off;
    end else if (kind < 70) begin
      off = jt + 1 + longint'($urandom_range(400));
      if ($urandom_range(1)) off = -off;
    end else if (kind < 85) begin
      anchor = $urandom_range(1) ? longint'(sb.max_dist) : longint'(sb.min_dist);
      return clamp_distance(anchor + longint'($urandom_range(6)) - 3);
    end else if (kind < 90) begin
      return $urandom_range(1) ? '1 : '0;
    end else begin
      return DIST_W'($urandom);
    end
    return clamp_distance(base + off);
  endfunction

  initial begin
    int                directed [$];
    logic [REG_BITS-1:0] jt;
    logic [REG_BITS-1:0] st;
    logic [REG_BITS-1:0] mx;
    logic [REG_BITS-1:0] mn;
    logic [REG_BITS-1:0] fl;

    sb = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: zero-filled window, range floor, jumps both ways, stable band edges,
    // samples straddling range_max and range_min, distance extremes.
    directed = '{0, 65535, 65535, 65485, 65484, 65300, 65000, 1000, 1000, 1050, 1051,
                 4000, 4001, 3999, 99, 100, 300, 250, 249, 101, 0, 65535};
    foreach (directed[i]) send_sample(DIST_W'(directed[i]));
    in_tvalid <= 1'b0;
    drain();

    // Fill reload: the window comes back full of the fill value, baseline included.
    configure(RST_JUMP, RST_STABLE, RST_MAX, RST_MIN, 16'hFFFF, 1'b1);
    send_sample('1);
    send_sample('0);
    send_sample(DIST_W'(30000));
    in_tvalid <= 1'b0;

    for (int p = 1; p <= PHASES; p++) begin
      drain();
      case (p)
        2: begin jt = 16'd0;     st = 16'd0;     mx = 16'hFFFF; mn = 16'd0;     fl = 16'd0;     end
        3: begin jt = 16'hFFFF;  st = 16'hFFFF;  mx = 16'hFFFF; mn = 16'd0;     fl = 16'hFFFF;  end
        4: begin jt = 16'hFFFF;  st = 16'd0;     mx = 16'd0;    mn = 16'hFFFF;  fl = 16'd12345; end
        5: begin jt = 16'd300;   st = 16'd100;   mx = 16'd30000; mn = 16'd20000; fl = 16'd30000; end
        6: begin
          jt = REG_BITS'($urandom); st = REG_BITS'($urandom);
          mx = REG_BITS'($urandom); mn = REG_BITS'($urandom); fl = REG_BITS'($urandom);
        end
        8: begin jt = 16'd100;   st = 16'hFFFF;  mx = 16'd50000; mn = 16'd500;   fl = 16'd0;     end
        default: begin
          jt = REG_BITS'($urandom_range(2000, 20));
          st = REG_BITS'($urandom_range(int'(jt)));
          mx = REG_BITS'($urandom_range(60000, 1000));
          mn = REG_BITS'($urandom_range(1000));
          fl = REG_BITS'($urandom);
        end
      endcase
      configure(jt, st, mx, mn, fl, p == 1 || p == 6);

      // one phase runs flat out on both sides; another backs the block up
      steady = (p == 5);
      if (p == 7) hold_request = HOLD_CYCLES;
      for (int n = 0; n < PHASE_ITEMS; n++) send_sample(pick_distance());
      in_tvalid <= 1'b0;
      steady = 1'b0;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
